/* hw/rtl/hrfp_pkg.sv */
package hrfp_pkg;

    // Character codes and checksum constants
    localparam logic [7:0] CharColon   = 8'h3A;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CsumSeed    = 8'h07;
    localparam logic [7:0] CsumGood    = 8'h55;
    localparam logic [3:0] PosSaturate = 4'd12;

    // Pair start positions that carry the id and value bytes
    localparam logic [3:0] PosIdLow    = 4'd2;
    localparam logic [3:0] PosIdHigh   = 4'd4;
    localparam logic [3:0] PosValLow   = 4'd8;
    localparam logic [3:0] PosValHigh  = 4'd10;

    // Register reset values and indexes
    localparam logic [15:0] VoltIdReset = 16'd60813;
    localparam logic [15:0] CurrIdReset = 16'd60815;
    localparam logic        RegVoltId   = 1'b0;
    localparam logic        RegCurrId   = 1'b1;

    // Reading kinds
    localparam logic KindVoltage = 1'b0;
    localparam logic KindCurrent = 1'b1;

    // One reading produced by the parser for the byte it sees
    typedef struct packed {
        logic               hit;
        logic               kind;
        logic signed [16:0] value;
    } t_reading;

    // Decode one ASCII hex digit: bit 4 flags a valid digit, bits 3:0 the nibble
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end
        return res;
    endfunction

endpackage

/* hw/rtl/hex_register_frame_parser_top.sv */
// Parses newline-terminated ASCII hex register frames from a serial byte
// stream and reports voltage and current readings. Each received character is
// one request on the input channel; a character is taken every cycle while the
// result side keeps up. A character passes through one input register and the
// decode and checksum logic; the reading of a frame is loaded into an output
// register when the staged newline that closes the frame advances. Only a
// newline that produces a reading waits for the output register to free up;
// all other characters flow regardless of the output side. The register ids at
// byte addresses 0 (voltage) and 4 (current) are written over the APB port; the
// user must write them while the block is idle; the block does not enforce it.
module hex_register_frame_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Character channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    // Reading channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_reading_kind,
    output logic signed [16:0] o_reading_value,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]        r_volt_id;
    logic [15:0]        r_curr_id;
    logic               r_stg_valid;
    logic [7:0]         r_stg_byte;
    logic               r_out_valid;
    logic               r_out_kind;
    logic signed [16:0] r_out_value;

    hrfp_pkg::t_reading res;
    logic               out_free;
    logic               stg_adv;
    logic               reg_wr;

    // Register port: always ready, index from the word address
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == hrfp_pkg::RegCurrId) ? {16'd0, r_curr_id}
                                                       : {16'd0, r_volt_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_id <= hrfp_pkg::VoltIdReset;
            r_curr_id <= hrfp_pkg::CurrIdReset;
        end else if (reg_wr) begin
            if (paddr[2] == hrfp_pkg::RegVoltId) begin
                r_volt_id <= pwdata[15:0];
            end else begin
                r_curr_id <= pwdata[15:0];
            end
        end
    end

    // Stage flow: hold a newline with a reading until the output slot frees
    assign out_free   = !r_out_valid || i_out_ready;
    assign stg_adv    = r_stg_valid && (!res.hit || out_free);
    assign o_in_ready = !r_stg_valid || stg_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_stg_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_stg_byte <= i_rx_byte;
        end
    end

    hrfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (stg_adv),
        .i_byte    (r_stg_byte),
        .i_volt_id (r_volt_id),
        .i_curr_id (r_curr_id),
        .o_result  (res)
    );

    // Output register: load a reading, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stg_adv && res.hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv && res.hit) begin
            r_out_kind  <= res.kind;
            r_out_value <= res.value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reading_kind  = r_out_kind;
    assign o_reading_value = r_out_value;

`ifndef ASSERT_OFF
    // A staged character that cannot advance stays put
    a_stg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_valid && !stg_adv |=> r_stg_valid && $stable(r_stg_byte))
        else $error("staged character lost or changed while stalled");

    // Readings come only from a newline
    a_hit_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stg_adv && res.hit |-> r_stg_byte == hrfp_pkg::CharNewline)
        else $error("reading produced by a non-newline character");

    // A voltage reading is a sign-extended 16-bit value
    a_volt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == hrfp_pkg::KindVoltage
        |-> r_out_value[16] == r_out_value[15])
        else $error("voltage reading out of 16-bit range");

    // A pending reading is never overwritten before it is taken
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_value))
        else $error("pending reading overwritten");
`endif

endmodule

/* hw/rtl/hrfp_parser.sv */
module hrfp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic [15:0]        i_volt_id,
    input  logic [15:0]        i_curr_id,
    output hrfp_pkg::t_reading o_result
);

    logic [3:0]  r_pos,        n_pos;
    logic        r_colon,      n_colon;
    logic        r_phase,      n_phase;
    logic [3:0]  r_high_nib,   n_high_nib;
    logic        r_high_valid, n_high_valid;
    logic [7:0]  r_csum,       n_csum;
    logic [15:0] r_id,         n_id;
    logic [15:0] r_value,      n_value;

    logic [4:0]         hex;
    logic [7:0]         pair_byte;
    logic [3:0]         start;
    logic               is_lf;
    logic               frame_good;
    logic               volt_match;
    logic               curr_match;
    logic signed [16:0] value_ext;

    // Decode the character and form the byte of a completed pair
    assign hex       = hrfp_pkg::hex_decode(i_byte);
    assign pair_byte = (hex[4] && r_high_valid) ? {r_high_nib, hex[3:0]} : 8'h00;
    assign start     = r_pos - 4'd1;
    assign is_lf     = (i_byte == hrfp_pkg::CharNewline);

    // Judge the frame closed by a newline
    assign frame_good = r_colon && (r_csum == hrfp_pkg::CsumGood);
    assign volt_match = (r_id == i_volt_id);
    assign curr_match = (r_id == i_curr_id);
    assign value_ext  = {r_value[15], r_value};

    always_comb begin
        o_result.hit   = is_lf && frame_good && (volt_match || curr_match);
        o_result.kind  = volt_match ? hrfp_pkg::KindVoltage : hrfp_pkg::KindCurrent;
        o_result.value = volt_match ? value_ext : 17'(17'sd0 - value_ext);
    end

    // Next parse state for the current character
    always_comb begin
        n_pos        = r_pos;
        n_colon      = r_colon;
        n_phase      = r_phase;
        n_high_nib   = r_high_nib;
        n_high_valid = r_high_valid;
        n_csum       = r_csum;
        n_id         = r_id;
        n_value      = r_value;
        if (is_lf) begin
            n_pos        = 4'd0;
            n_colon      = 1'b0;
            n_phase      = 1'b0;
            n_high_nib   = 4'd0;
            n_high_valid = 1'b0;
            n_csum       = hrfp_pkg::CsumSeed;
            n_id         = 16'd0;
            n_value      = 16'd0;
        end else begin
            if (r_pos == 4'd0) begin
                n_colon = (i_byte == hrfp_pkg::CharColon);
            end else if (r_pos >= 4'd2) begin
                if (!r_phase) begin
                    n_high_nib   = hex[3:0];
                    n_high_valid = hex[4];
                    n_phase      = 1'b1;
                end else begin
                    n_csum = r_csum + pair_byte;
                    if (start == hrfp_pkg::PosIdLow) begin
                        n_id[7:0] = pair_byte;
                    end else if (start == hrfp_pkg::PosIdHigh) begin
                        n_id[15:8] = pair_byte;
                    end else if (start == hrfp_pkg::PosValLow) begin
                        n_value[7:0] = pair_byte;
                    end else if (start == hrfp_pkg::PosValHigh) begin
                        n_value[15:8] = pair_byte;
                    end
                    n_phase      = 1'b0;
                    n_high_valid = 1'b0;
                    n_high_nib   = 4'd0;
                end
            end
            if (r_pos < hrfp_pkg::PosSaturate) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    // Advance the parse state on each consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 4'd0;
            r_colon      <= 1'b0;
            r_phase      <= 1'b0;
            r_high_nib   <= 4'd0;
            r_high_valid <= 1'b0;
            r_csum       <= hrfp_pkg::CsumSeed;
            r_id         <= 16'd0;
            r_value      <= 16'd0;
        end else if (i_fire) begin
            r_pos        <= n_pos;
            r_colon      <= n_colon;
            r_phase      <= n_phase;
            r_high_nib   <= n_high_nib;
            r_high_valid <= n_high_valid;
            r_csum       <= n_csum;
            r_id         <= n_id;
            r_value      <= n_value;
        end
    end

endmodule

/* bench/tb_hex_register_frame_parser_top.sv */
`timescale 1ns / 1ps

module tb_hex_register_frame_parser_top;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned MaxReports  = 10;

    typedef struct packed {
        logic               kind;
        logic signed [16:0] value;
    } t_exp_reading;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_reading_kind;
    logic signed [16:0] o_reading_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    hex_register_frame_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_reading_kind (o_reading_kind),
        .o_reading_value(o_reading_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Register ids as the parser should hold them
    logic [15:0] volt_id_cfg = hrfp_pkg::VoltIdReset;
    logic [15:0] curr_id_cfg = hrfp_pkg::CurrIdReset;

    // Line parser state mirrored from the block
    logic [3:0]  line_pos;
    logic        saw_colon;
    logic        in_pair;
    logic [3:0]  high_nib;
    logic        high_ok;
    logic [7:0]  csum;
    logic [15:0] frame_id;
    logic [15:0] frame_value;

    t_exp_reading expected_readings[$];
    t_exp_reading want_reading;
    logic [7:0]   frame_buf[$];

    int          mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned reader_stall_pct = 0;
    logic        ready_hold = 1'b0;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    function automatic void clear_line();
        line_pos    = '0;
        saw_colon   = 1'b0;
        in_pair     = 1'b0;
        high_nib    = '0;
        high_ok     = 1'b0;
        csum        = hrfp_pkg::CsumSeed;
        frame_id    = '0;
        frame_value = '0;
    endfunction

    // Advance the line parser by one character and queue any reading it closes
    function automatic void parse_char(input logic [7:0] c);
        logic [3:0]         nib;
        logic               ok;
        logic [7:0]         pair_byte;
        logic [3:0]         start;
        logic signed [16:0] wide;
        t_exp_reading       r;
        if (c == hrfp_pkg::CharNewline) begin
            if (saw_colon && csum == hrfp_pkg::CsumGood) begin
                wide = {frame_value[15], frame_value};
                if (frame_id == volt_id_cfg) begin
                    r.kind  = hrfp_pkg::KindVoltage;
                    r.value = wide;
                    expected_readings.push_back(r);
                end else if (frame_id == curr_id_cfg) begin
                    r.kind  = hrfp_pkg::KindCurrent;
                    r.value = -wide;
                    expected_readings.push_back(r);
                end
            end
            clear_line();
            return;
        end
        if (line_pos == 0) begin
            saw_colon = (c == hrfp_pkg::CharColon);
        end else if (line_pos >= 2) begin
            ok  = 1'b1;
            nib = '0;
            if (c >= "0" && c <= "9") begin
                nib = 4'(c - "0");
            end else if (c >= "A" && c <= "F") begin
                nib = 4'(c - "A" + 10);
            end else if (c >= "a" && c <= "f") begin
                nib = 4'(c - "a" + 10);
            end else begin
                ok = 1'b0;
            end
            if (!in_pair) begin
                high_nib = nib;
                high_ok  = ok;
                in_pair  = 1'b1;
            end else begin
                pair_byte = (ok && high_ok) ? {high_nib, nib} : 8'h00;
                start     = line_pos - 4'd1;
                csum      = csum + pair_byte;
                if (start == hrfp_pkg::PosIdLow) begin
                    frame_id[7:0] = pair_byte;
                end else if (start == hrfp_pkg::PosIdHigh) begin
                    frame_id[15:8] = pair_byte;
                end else if (start == hrfp_pkg::PosValLow) begin
                    frame_value[7:0] = pair_byte;
                end else if (start == hrfp_pkg::PosValHigh) begin
                    frame_value[15:8] = pair_byte;
                end
                in_pair  = 1'b0;
                high_ok  = 1'b0;
                high_nib = '0;
            end
        end
        if (line_pos < hrfp_pkg::PosSaturate) begin
            line_pos = line_pos + 4'd1;
        end
    endfunction

    // Drive the reading side ready, with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (ready_hold) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= reader_stall_pct);
        end
    end

    // Check each reading against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                note_mismatch("unexpected reading", -1, int'(o_reading_value));
            end else begin
                want_reading = expected_readings.pop_front();
                if (o_reading_kind !== want_reading.kind) begin
                    note_mismatch("reading_kind", int'(want_reading.kind),
                                  int'(o_reading_kind));
                end
                if (o_reading_value !== want_reading.value) begin
                    note_mismatch("reading_value", int'(want_reading.value),
                                  int'(o_reading_value));
                end
            end
        end
    end

    // Offer one character after a random gap and wait for its request to be taken
    task automatic send_char(input logic [7:0] c);
        int unsigned gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_char(c);
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) send_char(frame_buf[k]);
    endtask

    // Drop valid and hold until every reading is in and the pipeline is empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == hrfp_pkg::RegVoltId) begin
            volt_id_cfg = data[15:0];
        end else begin
            curr_id_cfg = data[15:0];
        end
        // Read back what was just written
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== data[15:0]) begin
            note_mismatch("register read", int'(data[15:0]), int'(prdata[15:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_ids(input logic [31:0] volt_word, input logic [31:0] curr_word);
        wait_drained();
        write_register(hrfp_pkg::RegVoltId, volt_word);
        write_register(hrfp_pkg::RegCurrId, curr_word);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10) return "0" + 8'(nib);
        return ($urandom_range(1) ? "a" : "A") + 8'(nib) - 8'd10;
    endfunction

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++) frame_buf.push_back(s[k]);
    endfunction

    // Build one frame for a register id and value, optionally damaged
    function automatic void build_frame(input logic [15:0] id, input logic [15:0] val,
                                        input bit may_damage);
        logic [7:0] body[$];
        logic [7:0] sum;
        int unsigned len;
        body = '{id[7:0], id[15:8], 8'($urandom), val[7:0], val[15:8]};
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        end
        sum = hrfp_pkg::CsumSeed;
        foreach (body[k]) sum = sum + body[k];
        body.push_back(hrfp_pkg::CsumGood - sum);
        frame_buf.delete();
        frame_buf.push_back(hrfp_pkg::CharColon);
        frame_buf.push_back(hex_char(4'($urandom)));
        foreach (body[k]) begin
            frame_buf.push_back(hex_char(body[k][7:4]));
            frame_buf.push_back(hex_char(body[k][3:0]));
        end
        if (may_damage && $urandom_range(3) == 0) begin
            case ($urandom_range(2))
                0: frame_buf[$urandom_range(frame_buf.size() - 1)] = 8'($urandom);
                1: begin
                    len = $urandom_range(1, frame_buf.size() - 1);
                    while (frame_buf.size() > len) void'(frame_buf.pop_back());
                end
                default: begin
                    repeat ($urandom_range(1, 4)) frame_buf.push_front(8'($urandom));
                end
            endcase
        end
        frame_buf.push_back(hrfp_pkg::CharNewline);
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 4) return volt_id_cfg;
        if (roll < 8) return curr_id_cfg;
        return 16'($urandom);
    endfunction

    // Reset ids: full frames at the value extremes, and a bare newline
    task automatic test_reset_ids();
        build_frame(hrfp_pkg::VoltIdReset, 16'h7FFF, 1'b0);
        send_frame();
        build_frame(hrfp_pkg::CurrIdReset, 16'h8000, 1'b0);
        send_frame();
        send_char(hrfp_pkg::CharNewline);
        wait_drained();
    endtask

    // Short frames, a newline inside a pair, a frame with no colon and non-hex characters
    task automatic test_short_frames();
        set_ids(32'h0000_004E, 32'h0000_0000);
        frame_buf.delete();
        push_text(":74E\n:74E5\n:700004E\n:\n74E\n");
        frame_buf.push_back(hrfp_pkg::CharColon);
        frame_buf.push_back(8'hFF);
        push_text("4E\n");
        frame_buf.push_back(hrfp_pkg::CharColon);
        frame_buf.push_back("7");
        frame_buf.push_back(8'h80);
        push_text("4E\n");
        send_frame();
        wait_drained();
    endtask

    // Same id in both registers: voltage wins; upper write bits are dropped
    task automatic test_equal_ids();
        set_ids(32'hABCD_FFFF, 32'h5432_FFFF);
        build_frame(16'hFFFF, 16'h8000, 1'b0);
        send_frame();
        build_frame(16'hFFFF, 16'h0001, 1'b0);
        send_frame();
        wait_drained();
    endtask

    // Random frames, damaged frames and line noise under one idling setting
    task automatic run_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                               input int unsigned char_budget);
        int unsigned sent = 0;
        sender_idle_pct  = idle_pct;
        reader_stall_pct = stall_pct;
        while (sent < char_budget) begin
            if ($urandom_range(9) == 0) begin
                frame_buf.delete();
                repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom));
                frame_buf.push_back(hrfp_pkg::CharNewline);
            end else begin
                build_frame(pick_id(), pick_value(), 1'b1);
            end
            send_frame();
            sent += frame_buf.size();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        set_ids({16'h0, hrfp_pkg::VoltIdReset}, {16'h0, hrfp_pkg::CurrIdReset});
        run_traffic(0, 0, 350);
        set_ids(32'h0000_0000, 32'hFFFF_FFFF);
        run_traffic(69, 0, 350);
        set_ids(32'h0000_FFFF, 32'h0000_0000);
        run_traffic(0, 69, 350);
        set_ids($urandom, $urandom);
        run_traffic(27, 27, 350);
    endtask

    // Hold the reading side off while frames keep coming, then pause the sender
    task automatic test_backpressure();
        set_ids($urandom, $urandom);
        sender_idle_pct  = 0;
        reader_stall_pct = 0;
        fork
            begin
                ready_hold <= 1'b1;
                repeat (400) @(posedge i_clk);
                ready_hold <= 1'b0;
            end
            begin
                repeat (12) begin
                    build_frame($urandom_range(1) ? volt_id_cfg : curr_id_cfg,
                                pick_value(), 1'b0);
                    send_frame();
                end
            end
        join
        wait_drained();
        repeat (4) begin
            build_frame(pick_id(), pick_value(), 1'b0);
            send_frame();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        clear_line();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_ids();
        test_short_frames();
        test_equal_ids();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
